// ----- design/bsi_pkg.sv -----
// Shared types, status codes and helpers for the bucket sort engine.
// Used by bsi_cell, bsi_row, bucketed_sorted_insert and bsi_check.
package bsi_pkg;

  // Widths sized for the largest supported bucket capacity (64 entries).
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [6:0] VALUE_MAX = 7'd99;

  // Request travelling down a bucket's row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             rd;      // read request, else insert
    logic             placed;  // insert point found, carrying a displaced entry
    logic             done;    // insert finished, pass through
    logic [6:0]       val;     // value to drop into the next cell
    logic [CNT_W-1:0] n;       // bucket fill when the request started
    logic [IDX_W-1:0] pos;     // read slot, or insert rank once found
    logic [6:0]       ent;     // value read, or value inserted
  } wave_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] bucket;
    logic [3:0] position;
    logic [6:0] entry;
    logic [4:0] fill;
  } result_t;

  // Bucket of a value in 0..99: value / 10 / 2.
  function automatic logic [2:0] bucket_of(input logic [6:0] v);
    logic [2:0] b;
    if (v >= 7'd80) begin
      b = 3'd4;
    end else if (v >= 7'd60) begin
      b = 3'd3;
    end else if (v >= 7'd40) begin
      b = 3'd2;
    end else if (v >= 7'd20) begin
      b = 3'd1;
    end else begin
      b = 3'd0;
    end
    return b;
  endfunction

endpackage

// ----- design/bsi_cell.sv -----
// One slot of a bucket: holds an entry and hands the passing request on.
// Depends on bsi_pkg.
module bsi_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  bsi_pkg::wave_t wave_in,
  output bsi_pkg::wave_t wave_out
);
  import bsi_pkg::*;

  localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_P = IDX_W'(IDX);

  logic [6:0] store;
  logic       wr;
  wave_t      w;

  always_comb begin
    w  = wave_in;
    wr = 1'b0;
    if (wave_in.valid) begin
      if (wave_in.rd) begin
        if (wave_in.pos == IDX_P) begin
          w.ent = store;
        end
      end else if (!wave_in.done) begin
        if (wave_in.n == IDX_N) begin
          // first empty slot: drop the carried value and finish
          wr     = 1'b1;
          w.done = 1'b1;
          if (!wave_in.placed) begin
            w.pos = IDX_P;
          end
        end else if (wave_in.placed || store >= wave_in.val) begin
          // swap: take the carried value, push the old entry right
          wr       = 1'b1;
          w.val    = store;
          w.placed = 1'b1;
          if (!wave_in.placed) begin
            w.pos = IDX_P;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store <= wave_in.val;
    end
  end

endmodule

// ----- design/bsi_row.sv -----
// One bucket: a row of bsi_cell slots chained left to right.
// Depends on bsi_pkg and bsi_cell.
module bsi_row #(
  parameter int CAP = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  bsi_pkg::wave_t wave_in,
  output bsi_pkg::wave_t wave_out
);
  import bsi_pkg::*;

  wave_t chain [0:CAP];

  assign chain[0] = wave_in;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    bsi_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (chain[i]),
      .wave_out (chain[i+1])
    );
  end

  assign wave_out = chain[CAP];

endmodule

// ----- design/bucketed_sorted_insert.sv -----
// Bucket sort engine: per-bucket rows of slot cells with a small controller in front.
// Depends on bsi_pkg, bsi_row and bsi_cell.
//
// An insert puts a value of 0..99 into bucket value/20, ahead of equal entries, in
// ascending order; a read returns the entry at a bucket and slot. One request is in
// flight at a time. Requests that need the storage travel the bucket's row of
// BUCKET_CAPACITY cells one cell per cycle; rejected requests (value out of range,
// full bucket, empty slot) skip the row and go from S_IDLE straight to S_DONE. A new
// request is accepted while the previous result still waits in the output register.
// Bucket counts clear on reset; stored entries need no clearing since only slots
// below the count are read.
module bucketed_sorted_insert #(
  parameter int NUM_BUCKETS     = 5,
  parameter int BUCKET_CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [6:0] value,
  input  logic [2:0] bucket_sel,
  input  logic [3:0] slot_sel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] bucket,
  output logic [3:0] position,
  output logic [6:0] entry,
  output logic [4:0] fill
);
  import bsi_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW = $clog2(BUCKET_CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  logic [CW-1:0]    count [NUM_BUCKETS];
  wave_t            inj;
  logic [BW-1:0]    act;
  result_t          res;
  result_t          out_res;

  wave_t            row_in  [NUM_BUCKETS];
  wave_t            row_out [NUM_BUCKETS];
  wave_t            row_end;

  logic [2:0]       vb;
  logic [2:0]       addr3;
  logic [4:0]       addr5;
  logic [BW-1:0]    idx;
  logic             bucket_ok;
  logic [CW-1:0]    n;
  logic [CNT_W-1:0] n7;
  logic [CNT_W-1:0] n_inc;
  logic [CNT_W-1:0] slot7;
  logic             walk;
  logic             ins_ok;
  result_t          res_next;
  wave_t            inj_next;

  // Request decode and early rejection
  always_comb begin
    vb        = bucket_of(value);
    addr3     = kind ? bucket_sel : vb;
    addr5     = {2'b00, addr3};
    idx       = addr5[BW-1:0];
    bucket_ok = addr5 < 5'(NUM_BUCKETS);
    n         = bucket_ok ? count[idx] : '0;
    n7        = CNT_W'(n);
    n_inc     = n7 + CNT_W'(1);
    slot7     = CNT_W'(slot_sel);
    walk      = 1'b0;
    ins_ok    = 1'b0;
    res_next  = '{status: ST_OK, bucket: addr3, position: slot_sel,
                  entry: 7'd0, fill: n7[4:0]};
    if (!kind) begin
      res_next.position = 4'd0;
      res_next.entry    = value;
      if (value > VALUE_MAX || !bucket_ok) begin
        res_next.status = ST_RANGE;
        res_next.bucket = 3'd0;
        res_next.fill   = 5'd0;
      end else if (n7 >= CNT_W'(BUCKET_CAPACITY)) begin
        res_next.status = ST_FULL;
      end else begin
        walk          = 1'b1;
        ins_ok        = 1'b1;
        res_next.fill = n_inc[4:0];
      end
    end else begin
      if (!bucket_ok) begin
        res_next.status = ST_EMPTY;
        res_next.fill   = 5'd0;
      end else if (slot7 >= n7 || slot7 >= CNT_W'(BUCKET_CAPACITY)) begin
        res_next.status = ST_EMPTY;
      end else begin
        walk = 1'b1;
      end
    end
    inj_next = '{valid: 1'b1, rd: kind, placed: 1'b0, done: 1'b0, val: value,
                 n: n7, pos: IDX_W'(slot_sel), ent: kind ? 7'd0 : value};
  end

  assign in_ready = (state == S_IDLE);

  for (genvar r = 0; r < NUM_BUCKETS; r++) begin : g_row
    always_comb begin
      row_in[r]       = inj;
      row_in[r].valid = inj.valid && (act == BW'(r));
    end

    bsi_row #(.CAP(BUCKET_CAPACITY)) u_row (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (row_in[r]),
      .wave_out (row_out[r])
    );
  end

  assign row_end = row_out[act];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inj       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res <= res_next;
            act <= idx;
            if (ins_ok) begin
              count[idx] <= n + CW'(1);
            end
            if (walk) begin
              inj   <= inj_next;
              state <= S_WALK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          // inject for one cycle only
          inj.valid <= 1'b0;
          if (row_end.valid) begin
            res.position <= row_end.pos[3:0];
            res.entry    <= row_end.ent;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register frees up
          if (!out_valid || out_ready) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status   = out_res.status;
  assign bucket   = out_res.bucket;
  assign position = out_res.position;
  assign entry    = out_res.entry;
  assign fill     = out_res.fill;

endmodule

// ----- design/bsi_check.sv -----
// Port-level checks for bucketed_sorted_insert, attached by bind.
// Depends on bsi_pkg.
module bsi_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [2:0] bucket,
  input logic [3:0] position,
  input logic [6:0] entry,
  input logic [4:0] fill
);
  import bsi_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ok_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> entry <= VALUE_MAX && fill != 5'd0)
    else $error("ok result with bad entry or empty bucket");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> bucket == 3'd0 && position == 4'd0 && fill == 5'd0)
    else $error("range reject with nonzero bucket, position or fill");

  a_empty_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry == 7'd0)
    else $error("empty-slot read returned data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry) && $stable(fill))
    else $error("stalled result changed");

endmodule

bind bucketed_sorted_insert bsi_check u_bsi_check (.*);

// ----- tb/tb_bucketed_sorted_insert.sv -----
// Self-checking testbench for the bucketed_sorted_insert bucket sort engine.
// Depends on bsi_pkg for the status codes and the result layout.
// Keeps its own image of every bucket and checks each result against it in order.
module tb_bucketed_sorted_insert;
  timeunit 1ns;
  timeprecision 1ps;

  import bsi_pkg::*;

  localparam int NB  = 5;
  localparam int CAP = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       kind = KIND_INSERT;
  logic [6:0] value = '0;
  logic [2:0] bucket_sel = '0;
  logic [3:0] slot_sel = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [2:0] bucket;
  logic [3:0] position;
  logic [6:0] entry;
  logic [4:0] fill;

  bucketed_sorted_insert #(
    .NUM_BUCKETS     (NB),
    .BUCKET_CAPACITY (CAP)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .value      (value),
    .bucket_sel (bucket_sel),
    .slot_sel   (slot_sel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .bucket     (bucket),
    .position   (position),
    .entry      (entry),
    .fill       (fill)
  );

  // Sorted image of each bucket, updated as requests are accepted.
  logic [6:0] bucket_image [NB][CAP];
  int         bucket_fill [NB];
  result_t    pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int requests_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("tb_bucketed_sorted_insert: errors");
    $finish;
  end

  // Work out the result of one request and update the bucket image.
  function automatic result_t apply_request(input logic k, input logic [6:0] v,
                                            input logic [2:0] bs, input logic [3:0] ss);
    result_t r;
    int      b;
    int      n;
    int      p;
    r = '0;
    if (k == KIND_INSERT) begin
      b = v / 20;
      if (v > VALUE_MAX || b >= NB) begin
        r.status = ST_RANGE;
        r.entry  = v;
      end else begin
        n = bucket_fill[b];
        r.bucket = 3'(b);
        r.entry  = v;
        if (n >= CAP) begin
          r.status = ST_FULL;
          r.fill   = 5'(n);
        end else begin
          // Stop at the first entry not below v so equal values go behind the new one.
          p = 0;
          while (p < n && bucket_image[b][p] < v) p++;
          for (int i = n; i > p; i--) bucket_image[b][i] = bucket_image[b][i-1];
          bucket_image[b][p] = v;
          bucket_fill[b] = n + 1;
          r.status   = ST_OK;
          r.position = 4'(p);
          r.fill     = 5'(n + 1);
        end
      end
    end else begin
      r.bucket   = bs;
      r.position = ss;
      if (bs >= NB) begin
        r.status = ST_EMPTY;
      end else if (ss >= bucket_fill[bs]) begin
        r.status = ST_EMPTY;
        r.fill   = 5'(bucket_fill[bs]);
      end else begin
        r.status = ST_OK;
        r.entry  = bucket_image[bs][ss];
        r.fill   = 5'(bucket_fill[bs]);
      end
    end
    status_hits[r.status]++;
    return r;
  endfunction

  // Offer one request, keeping valid high across back-to-back requests.
  task automatic send_request(input logic k, input logic [6:0] v,
                              input logic [2:0] bs, input logic [3:0] ss);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    value      <= v;
    bucket_sel <= bs;
    slot_sel   <= ss;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(k, v, bs, ss));
    requests_sent++;
  endtask

  // Receiver: a hold-off takes priority over the random stall.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_result();
    result_t got;
    result_t want;
    got.status   = status;
    got.bucket   = bucket;
    got.position = position;
    got.entry    = entry;
    got.fill     = fill;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result st=%0d bk=%0d pos=%0d ent=%0d fill=%0d",
                 $realtime, got.status, got.bucket, got.position, got.entry, got.fill);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch exp st=%0d bk=%0d pos=%0d ent=%0d fill=%0d, got st=%0d bk=%0d pos=%0d ent=%0d fill=%0d",
                   $realtime, want.status, want.bucket, want.position, want.entry, want.fill,
                   got.status, got.bucket, got.position, got.entry, got.fill);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  task automatic test_directed_edges();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(KIND_READ,   7'd0,   3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd0,   3'd7, 4'd15);
    send_request(KIND_INSERT, 7'd99,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd100, 3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd127, 3'd7, 4'd15);
    send_request(KIND_INSERT, 7'd19,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd20,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd5,   3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd5,   3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd0,   3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd79,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd80,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd40,  3'd0, 4'd0);
    send_request(KIND_INSERT, 7'd59,  3'd0, 4'd0);
    send_request(KIND_READ,   7'd127, 3'd0, 4'd0);
    send_request(KIND_READ,   7'd0,   3'd0, 4'd2);
    send_request(KIND_READ,   7'd0,   3'd0, 4'd4);
    send_request(KIND_READ,   7'd0,   3'd0, 4'd5);
    send_request(KIND_READ,   7'd0,   3'd0, 4'd15);
    send_request(KIND_READ,   7'd0,   3'd4, 4'd1);
    send_request(KIND_READ,   7'd0,   3'd5, 4'd0);
    send_request(KIND_READ,   7'd0,   3'd6, 4'd7);
    send_request(KIND_READ,   7'd0,   3'd7, 4'd15);
  endtask

  task automatic run_mix(input int items, input int send_pct, input int recv_pct,
                         input int insert_pct);
    int         b;
    int         f;
    logic [6:0] v;
    logic [2:0] bs;
    logic [3:0] ss;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < insert_pct) begin
        b = $urandom_range(NB - 1);
        // Reuse a stored value now and then to exercise equal-entry ordering.
        if (bucket_fill[b] != 0 && $urandom_range(4) == 0)
          v = bucket_image[b][$urandom_range(bucket_fill[b] - 1)];
        else if ($urandom_range(19) == 0)
          v = 7'($urandom_range(127, 100));
        else
          v = 7'($urandom_range(99));
        send_request(KIND_INSERT, v, 3'($urandom), 4'($urandom));
      end else begin
        bs = ($urandom_range(15) == 0) ? 3'($urandom_range(7, NB)) : 3'($urandom_range(NB - 1));
        f = (bs < NB) ? bucket_fill[bs] : 0;
        if (f != 0 && $urandom_range(3) != 0) ss = 4'($urandom_range(f - 1));
        else ss = 4'($urandom);
        send_request(KIND_READ, 7'($urandom), bs, ss);
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 80;
    hold_seq <= hold_seq + 1;
    run_mix(12, 0, 0, 50);
  endtask

  task automatic test_random_mix();
    run_mix(130, 11, 45, 35);
    run_mix(130, 45, 11, 35);
    run_mix(140, 0, 0, 35);
  endtask

  task automatic test_fill_bucket();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    while (bucket_fill[2] < CAP)
      send_request(KIND_INSERT, 7'($urandom_range(59, 40)), 3'($urandom), 4'($urandom));
    repeat (2)
      send_request(KIND_INSERT, 7'($urandom_range(59, 40)), 3'($urandom), 4'($urandom));
    for (int s = 0; s < CAP; s++) send_request(KIND_READ, 7'($urandom), 3'd2, 4'(s));
  endtask

  initial begin
    for (int b = 0; b < NB; b++) bucket_fill[b] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_backpressure();
    test_random_mix();
    test_fill_bucket();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    mismatch_count += pending_results.size();

    $display("sent %0d requests, checked %0d results, %0d mismatches",
             requests_sent, results_checked, mismatch_count);
    $display("status mix: ok %0d, full %0d, out of range %0d, empty slot %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_RANGE],
             status_hits[ST_EMPTY]);
    if (mismatch_count == 0) begin
      $display("tb_bucketed_sorted_insert: clean");
    end else begin
      $display("tb_bucketed_sorted_insert: errors");
    end
    $finish;
  end

endmodule
